/* hdl/clra_pkg.sv */
package clra_pkg;

  localparam int unsigned DFLT_W = 7;
  localparam int unsigned NPROC_W = 5;
  localparam int unsigned PROC_W = 4;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [DFLT_W-1:0] DFLT_RST = 7'd4;
  localparam logic [NPROC_W-1:0] NPROC_RST = 5'd16;
  localparam int unsigned CNT_RST = 4;

  localparam logic REQ_LEND = 1'b0;
  localparam logic REQ_RECLAIM = 1'b1;

  // register select on paddr[2]
  localparam logic REG_DFLT = 1'b0;
  localparam logic REG_NPROC = 1'b1;

  typedef struct packed {
    logic ld;
    logic head;
    logic lwalk;
    logic lwp;
    logic rwalk;
    logic fin;
  } clra_cmd_t;

  typedef struct packed {
    logic bad;
    logic lend;
    logic lw_stop;
    logic lw_found;
    logic rw_stop;
    logic out_busy;
  } clra_sts_t;

endpackage

/* hdl/clra_ram.sv */
module clra_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/clra_ctrl.sv */
module clra_ctrl import clra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  clra_sts_t sts,
  output clra_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_LWALK = 3'd2;
  localparam logic [2:0] S_LWRP  = 3'd3;
  localparam logic [2:0] S_RWALK = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head = 1'b1;
        priority if (sts.bad) begin
          state_nxt = S_FIN;
        end else if (sts.lend) begin
          state_nxt = S_LWALK;
        end else begin
          state_nxt = S_RWALK;
        end
      end
      S_LWALK: begin
        cmd.lwalk = 1'b1;
        if (sts.lw_stop) begin
          state_nxt = sts.lw_found ? S_LWRP : S_FIN;
        end
      end
      S_LWRP: begin
        cmd.lwp = 1'b1;
        state_nxt = S_FIN;
      end
      S_RWALK: begin
        cmd.rwalk = 1'b1;
        if (sts.rw_stop) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/clra_dp.sv */
module clra_dp import clra_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clra_cmd_t             cmd,
  output clra_sts_t             sts,
  input  logic                  in_req_type,
  input  logic [PROC_W-1:0]     in_proc_index,
  input  logic [DFLT_W-1:0]     dflt,
  input  logic [NPROC_W-1:0]    nproc,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_changed_valid,
  output logic [PROC_W-1:0]     out_changed_proc,
  output logic [COUNT_BITS-1:0] out_changed_count,
  output logic [COUNT_BITS-1:0] out_requester_count,
  output logic [COUNT_BITS-1:0] out_idle_count,
  output logic                  out_bad_request
);

  localparam int unsigned IDX_W = $clog2(MAX_PROCS);
  localparam int unsigned CW = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_INIT = COUNT_BITS'(CNT_RST);

  logic [PROC_W-1:0]     p_r;
  logic                  lend_r;
  logic [IDX_W-1:0]      wa_r;
  logic [CW-1:0]         amount_r;
  logic                  chg_r;
  logic [IDX_W-1:0]      cidx_r;
  logic [COUNT_BITS-1:0] ccount_r;
  logic [COUNT_BITS-1:0] reqc_r;
  logic                  bad_r;
  logic [COUNT_BITS-1:0] idle_r;
  logic [MAX_PROCS-1:0]  valid_r;
  logic                  vq_r;

  logic                  out_valid_r;
  logic                  out_chg_r;
  logic [PROC_W-1:0]     out_proc_r;
  logic [COUNT_BITS-1:0] out_ccount_r;
  logic [COUNT_BITS-1:0] out_reqc_r;
  logic [COUNT_BITS-1:0] out_idle_r;
  logic                  out_bad_r;

  logic [8:0]            np9;
  logic [8:0]            ring9;
  logic [8:0]            p9;
  logic [8:0]            in9;
  logic [8:0]            cidx9;
  logic [8:0]            p_inc;
  logic [8:0]            wa_inc;
  logic [IDX_W-1:0]      pidx;
  logic [IDX_W-1:0]      p_nx;
  logic [IDX_W-1:0]      wa_nx;
  logic                  pok;

  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] cur;
  logic [CW-1:0]         cur_e;
  logic [CW-1:0]         dflt_e;
  logic [CW-1:0]         dflt2_e;
  logic [CW-1:0]         idle_e;
  logic [CW-1:0]         sub_e;
  logic [COUNT_BITS-1:0] dflt_sat;
  logic [CW:0]           sum_l;
  logic [CW:0]           sum_i;
  logic [COUNT_BITS-1:0] sat_l;
  logic [COUNT_BITS-1:0] sat_i;
  logic                  c_ge2;
  logic                  c_gt;
  logic                  bad;
  logic                  lw_stop;
  logic                  lw_found;
  logic                  rw_stop;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [IDX_W-1:0]      raddr;

  // ring size and ring successor
  assign np9 = 9'(nproc);
  assign ring9 = (np9 == 9'd0) ? 9'd1 :
                 (np9 > 9'(MAX_PROCS)) ? 9'(MAX_PROCS) : np9;
  assign p9 = 9'(p_r);
  assign in9 = 9'(in_proc_index);
  assign cidx9 = 9'(cidx_r);
  assign pidx = p9[IDX_W-1:0];
  assign pok = (p9 < ring9);
  assign p_inc = 9'(pidx) + 9'd1;
  assign wa_inc = 9'(wa_r) + 9'd1;
  assign p_nx = (p_inc == ring9) ? '0 : p_inc[IDX_W-1:0];
  assign wa_nx = (wa_inc == ring9) ? '0 : wa_inc[IDX_W-1:0];

  // entry never written reads as its reset count
  assign cur = vq_r ? rdata : CNT_INIT;

  assign cur_e = CW'(cur);
  assign dflt_e = CW'(dflt);
  assign dflt2_e = dflt_e << 1;
  assign idle_e = CW'(idle_r);
  assign sub_e = cur_e - dflt_e;
  assign dflt_sat = (dflt_e > CW'(CNT_MAX)) ? CNT_MAX : dflt_e[COUNT_BITS-1:0];
  assign sum_l = (CW+1)'(cur) + (CW+1)'(amount_r);
  assign sum_i = (CW+1)'(idle_r) + (CW+1)'(amount_r);
  assign sat_l = (sum_l > (CW+1)'(CNT_MAX)) ? CNT_MAX : sum_l[COUNT_BITS-1:0];
  assign sat_i = (sum_i > (CW+1)'(CNT_MAX)) ? CNT_MAX : sum_i[COUNT_BITS-1:0];
  assign c_ge2 = (cur_e >= dflt2_e);
  assign c_gt = (cur_e > dflt_e);

  assign bad = !pok || (lend_r ? (cur == '0) : (cur != '0));
  assign lw_found = (wa_r != pidx) && (cur != '0);
  assign lw_stop = (wa_r == pidx) || (cur != '0);
  assign rw_stop = !(amount_r < dflt_e) || (wa_r == pidx);

  assign sts.bad = bad;
  assign sts.lend = lend_r;
  assign sts.lw_stop = lw_stop;
  assign sts.lw_found = lw_found;
  assign sts.rw_stop = rw_stop;
  assign sts.out_busy = out_valid_r && out_stall;

  always_comb begin
    we = 1'b0;
    waddr = wa_r;
    wdata = '0;
    if (cmd.lwalk && lw_found) begin
      we = 1'b1;
      wdata = sat_l;
    end else if (cmd.lwalk && lw_stop) begin
      we = 1'b1;
      waddr = pidx;
    end else if (cmd.lwp) begin
      we = 1'b1;
      waddr = pidx;
    end else if (cmd.rwalk && rw_stop) begin
      we = 1'b1;
      waddr = pidx;
      wdata = dflt_sat;
    end else if (cmd.rwalk && c_ge2) begin
      we = 1'b1;
      wdata = sub_e[COUNT_BITS-1:0];
    end else if (cmd.rwalk && c_gt) begin
      we = 1'b1;
      wdata = dflt_e[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    priority if (cmd.ld) begin
      raddr = in9[IDX_W-1:0];
    end else if (cmd.head) begin
      raddr = p_nx;
    end else begin
      raddr = wa_nx;
    end
  end

  clra_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_PROCS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= '0;
      valid_r <= '0;
      vq_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vq_r <= valid_r[raddr];
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (cmd.head && !bad && !lend_r) begin
        idle_r <= (idle_e >= dflt_e) ? (idle_r - dflt_e[COUNT_BITS-1:0]) : '0;
      end else if (cmd.lwalk && lw_stop && !lw_found) begin
        idle_r <= sat_i;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      p_r <= in_proc_index;
      lend_r <= (in_req_type == REQ_LEND);
      chg_r <= 1'b0;
      bad_r <= 1'b0;
    end
    if (cmd.head) begin
      bad_r <= bad;
      reqc_r <= pok ? cur : '0;
      wa_r <= p_nx;
      if (lend_r) begin
        amount_r <= cur_e;
      end else begin
        amount_r <= (idle_e >= dflt_e) ? dflt_e : idle_e;
      end
    end
    if (cmd.lwalk) begin
      if (lw_found) begin
        chg_r <= 1'b1;
        cidx_r <= wa_r;
        ccount_r <= sat_l;
      end else if (lw_stop) begin
        reqc_r <= '0;
      end else begin
        wa_r <= wa_nx;
      end
    end
    if (cmd.lwp) begin
      reqc_r <= '0;
    end
    if (cmd.rwalk) begin
      if (rw_stop) begin
        reqc_r <= dflt_sat;
      end else begin
        if (c_ge2) begin
          amount_r <= dflt_e;
          chg_r <= 1'b1;
          cidx_r <= wa_r;
          ccount_r <= sub_e[COUNT_BITS-1:0];
        end else if (c_gt) begin
          amount_r <= sub_e;
          chg_r <= 1'b1;
          cidx_r <= wa_r;
          ccount_r <= dflt_e[COUNT_BITS-1:0];
        end
        wa_r <= wa_nx;
      end
    end
    if (cmd.fin) begin
      out_chg_r <= chg_r;
      out_proc_r <= chg_r ? cidx9[PROC_W-1:0] : '0;
      out_ccount_r <= chg_r ? ccount_r : '0;
      out_reqc_r <= reqc_r;
      out_idle_r <= idle_r;
      out_bad_r <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_changed_valid = out_chg_r;
  assign out_changed_proc = out_proc_r;
  assign out_changed_count = out_ccount_r;
  assign out_requester_count = out_reqc_r;
  assign out_idle_count = out_idle_r;
  assign out_bad_request = out_bad_r;

endmodule

/* hdl/cpu_lend_reclaim_allocator_unit.sv */
// out_valid follows an accepted request after the head, walk and finish states, plus any out_stall wait
// throughput: one request in flight; the next is taken the cycle after its result is registered
// the ring walk reads one table entry per cycle through the single table read port
// reset: counts read as 4 per process via per-entry valid bits, idle pool 0,
// default_threads 4, ring size 16; no clearing pass
module cpu_lend_reclaim_allocator_unit import clra_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [PROC_W-1:0]     in_proc_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_changed_valid,
  output logic [PROC_W-1:0]     out_changed_proc,
  output logic [COUNT_BITS-1:0] out_changed_count,
  output logic [COUNT_BITS-1:0] out_requester_count,
  output logic [COUNT_BITS-1:0] out_idle_count,
  output logic                  out_bad_request,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  logic [DFLT_W-1:0]  dflt_r;
  logic [NPROC_W-1:0] nproc_r;
  logic               cfg_wr;
  clra_cmd_t          cmd;
  clra_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= DFLT_RST;
      nproc_r <= NPROC_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DFLT) begin
        dflt_r <= pwdata[DFLT_W-1:0];
      end else begin
        nproc_r <= pwdata[NPROC_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_NPROC) ? PDATA_W'(nproc_r) : PDATA_W'(dflt_r);

  clra_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  clra_dp #(
    .MAX_PROCS (MAX_PROCS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_req_type),
    .in_proc_index      (in_proc_index),
    .dflt               (dflt_r),
    .nproc              (nproc_r),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_changed_valid  (out_changed_valid),
    .out_changed_proc   (out_changed_proc),
    .out_changed_count  (out_changed_count),
    .out_requester_count(out_requester_count),
    .out_idle_count     (out_idle_count),
    .out_bad_request    (out_bad_request)
  );

  a_bad_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> !out_changed_valid)
    else $error("rejected request reports a changed entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  a_unchanged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_changed_valid |-> (out_changed_count == '0) && (out_changed_proc == '0))
    else $error("changed fields set without a change");

endmodule
